>>> rtl/acpu_pkg.sv
package acpu_pkg;

  // memory geometry
  localparam int MEM_DEPTH = 256;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DATA_W    = 8;

  // request kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_STEP    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_DIV0    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  // opcodes
  localparam logic [3:0] OP_HLT = 4'h0;
  localparam logic [3:0] OP_UNK = 4'h1;
  localparam logic [3:0] OP_LDA = 4'h2;
  localparam logic [3:0] OP_STA = 4'h3;
  localparam logic [3:0] OP_ADD = 4'hC;
  localparam logic [3:0] OP_SUB = 4'hD;
  localparam logic [3:0] OP_MUL = 4'hE;
  localparam logic [3:0] OP_DIV = 4'hF;

  // datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_WRITE,
    DP_READ,
    DP_READ_DONE,
    DP_RESTART,
    DP_HALTED,
    DP_FETCH_OP,
    DP_FETCH_ADDR,
    DP_FETCH_VAL,
    DP_EXEC,
    DP_DIV_STEP,
    DP_DIV_END
  } dp_op_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_READ_LATCH,
    S_RESTART,
    S_HALTED,
    S_FETCH_OP,
    S_FETCH_ADDR,
    S_FETCH_VAL,
    S_EXEC,
    S_DIV,
    S_DIV_END,
    S_DONE
  } ctl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   result_strobe;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       halted;
    logic [3:0] opcode;
    logic       operand_zero;
    logic       div_last;
  } sts_t;

endpackage

>>> rtl/acpu_ctrl.sv
module acpu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  acpu_pkg::sts_t      sts,
  output acpu_pkg::cmd_t      cmd,
  output logic                busy
);

  acpu_pkg::ctl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acpu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next        = state;
    cmd.op            = acpu_pkg::DP_NOP;
    cmd.result_strobe = 1'b0;
    busy              = 1'b1;
    unique case (state)
      acpu_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op = acpu_pkg::DP_LOAD;
          unique case (kind)
            acpu_pkg::KIND_WRITE: state_next = acpu_pkg::S_WRITE;
            acpu_pkg::KIND_READ:  state_next = acpu_pkg::S_READ;
            acpu_pkg::KIND_STEP: begin
              if (sts.halted) begin
                state_next = acpu_pkg::S_HALTED;
              end else begin
                state_next = acpu_pkg::S_FETCH_OP;
              end
            end
            default: state_next = acpu_pkg::S_RESTART;
          endcase
        end
      end
      acpu_pkg::S_WRITE: begin
        cmd.op     = acpu_pkg::DP_WRITE;
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_READ: begin
        cmd.op     = acpu_pkg::DP_READ;
        state_next = acpu_pkg::S_READ_LATCH;
      end
      acpu_pkg::S_READ_LATCH: begin
        cmd.op     = acpu_pkg::DP_READ_DONE;
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_RESTART: begin
        cmd.op     = acpu_pkg::DP_RESTART;
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_HALTED: begin
        cmd.op     = acpu_pkg::DP_HALTED;
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_FETCH_OP: begin
        cmd.op     = acpu_pkg::DP_FETCH_OP;
        state_next = acpu_pkg::S_FETCH_ADDR;
      end
      acpu_pkg::S_FETCH_ADDR: begin
        cmd.op     = acpu_pkg::DP_FETCH_ADDR;
        state_next = acpu_pkg::S_FETCH_VAL;
      end
      acpu_pkg::S_FETCH_VAL: begin
        cmd.op     = acpu_pkg::DP_FETCH_VAL;
        state_next = acpu_pkg::S_EXEC;
      end
      acpu_pkg::S_EXEC: begin
        cmd.op = acpu_pkg::DP_EXEC;
        if (sts.opcode == acpu_pkg::OP_DIV && !sts.operand_zero) begin
          state_next = acpu_pkg::S_DIV;
        end else begin
          state_next = acpu_pkg::S_DONE;
        end
      end
      acpu_pkg::S_DIV: begin
        cmd.op = acpu_pkg::DP_DIV_STEP;
        if (sts.div_last) begin
          state_next = acpu_pkg::S_DIV_END;
        end
      end
      acpu_pkg::S_DIV_END: begin
        cmd.op     = acpu_pkg::DP_DIV_END;
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_DONE: begin
        cmd.result_strobe = 1'b1;
        state_next        = acpu_pkg::S_IDLE;
      end
      default: state_next = acpu_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/acpu_dpath.sv
module acpu_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  acpu_pkg::cmd_t                cmd,
  input  logic [acpu_pkg::ADDR_W-1:0]   address,
  input  logic [acpu_pkg::DATA_W-1:0]   write_data,
  output acpu_pkg::sts_t                sts,
  output logic [acpu_pkg::DATA_W-1:0]   read_data,
  output logic [acpu_pkg::ADDR_W-1:0]   pc_now,
  output logic [acpu_pkg::DATA_W-1:0]   acc_now,
  output logic [3:0]                    executed_opcode,
  output logic [2:0]                    status
);

  localparam int CNT_W = $clog2(acpu_pkg::DATA_W);

  // unified memory with per-entry valid bits for the reset clear
  logic [acpu_pkg::DATA_W-1:0]  mem [acpu_pkg::MEM_DEPTH];
  logic [acpu_pkg::MEM_DEPTH-1:0] mem_vld;
  logic [acpu_pkg::DATA_W-1:0]  mem_q;
  logic                         mem_vld_q;
  logic [acpu_pkg::DATA_W-1:0]  rd_val;

  // architectural and request registers
  logic [acpu_pkg::ADDR_W-1:0]  addr_q;
  logic [acpu_pkg::DATA_W-1:0]  wdata_q;
  logic [acpu_pkg::ADDR_W-1:0]  pc;
  logic [acpu_pkg::DATA_W-1:0]  acc;
  logic                         halted;
  logic [3:0]                   opcode;
  logic [acpu_pkg::ADDR_W-1:0]  opaddr;
  logic [acpu_pkg::DATA_W-1:0]  rdata;
  logic [2:0]                   st;

  // divider registers
  logic [acpu_pkg::DATA_W-1:0]  div_rem;
  logic [acpu_pkg::DATA_W-1:0]  div_quo;
  logic [acpu_pkg::DATA_W-1:0]  div_dsr;
  logic [CNT_W-1:0]             div_cnt;
  logic [acpu_pkg::DATA_W:0]    div_trial;

  // memory port controls
  logic                         mem_we;
  logic [acpu_pkg::ADDR_W-1:0]  mem_waddr;
  logic [acpu_pkg::DATA_W-1:0]  mem_wdata;
  logic                         mem_re;
  logic [acpu_pkg::ADDR_W-1:0]  mem_raddr;

  logic [acpu_pkg::ADDR_W-1:0]  pc_plus2;

  assign rd_val   = mem_vld_q ? mem_q : '0;
  assign pc_plus2 = pc + acpu_pkg::ADDR_W'(2);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = wdata_q;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    unique case (cmd.op)
      acpu_pkg::DP_WRITE: mem_we = 1'b1;
      acpu_pkg::DP_READ:  mem_re = 1'b1;
      acpu_pkg::DP_FETCH_OP: begin
        mem_re    = 1'b1;
        mem_raddr = pc;
      end
      acpu_pkg::DP_FETCH_ADDR: begin
        mem_re    = 1'b1;
        mem_raddr = pc + acpu_pkg::ADDR_W'(1);
      end
      acpu_pkg::DP_FETCH_VAL: begin
        mem_re    = 1'b1;
        mem_raddr = rd_val;
      end
      acpu_pkg::DP_EXEC: begin
        mem_we    = (opcode == acpu_pkg::OP_STA);
        mem_waddr = opaddr;
        mem_wdata = acc;
      end
      default: ;
    endcase
  end

  // memory array
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q     <= mem[mem_raddr];
      mem_vld_q <= mem_vld[mem_raddr];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (mem_we) begin
      mem_vld[mem_waddr] <= 1'b1;
    end
  end

  // restoring divide trial
  assign div_trial = {div_rem, div_quo[acpu_pkg::DATA_W-1]} - {1'b0, div_dsr};

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      acc    <= '0;
      halted <= 1'b0;
    end else begin
      unique case (cmd.op)
        acpu_pkg::DP_RESTART: begin
          pc     <= addr_q;
          halted <= 1'b0;
        end
        acpu_pkg::DP_EXEC: begin
          unique case (opcode)
            acpu_pkg::OP_HLT, acpu_pkg::OP_UNK: halted <= 1'b1;
            acpu_pkg::OP_LDA: begin
              acc <= rd_val;
              pc  <= pc_plus2;
            end
            acpu_pkg::OP_ADD: begin
              acc <= acc + rd_val;
              pc  <= pc_plus2;
            end
            acpu_pkg::OP_SUB: begin
              acc <= acc - rd_val;
              pc  <= pc_plus2;
            end
            acpu_pkg::OP_MUL: begin
              acc <= acpu_pkg::DATA_W'(acc * rd_val);
              pc  <= pc_plus2;
            end
            acpu_pkg::OP_DIV: begin
              if (rd_val == '0) begin
                halted <= 1'b1;
              end
            end
            default: pc <= pc_plus2;
          endcase
        end
        acpu_pkg::DP_DIV_END: begin
          acc <= div_quo;
          pc  <= pc_plus2;
        end
        default: ;
      endcase
    end
  end

  // request capture, fetch latches, result fields and divider
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      acpu_pkg::DP_LOAD: begin
        addr_q  <= address;
        wdata_q <= write_data;
        rdata   <= '0;
        opcode  <= '0;
        st      <= acpu_pkg::ST_OK;
      end
      acpu_pkg::DP_READ_DONE: rdata <= rd_val;
      acpu_pkg::DP_HALTED:    st    <= acpu_pkg::ST_HALTED;
      acpu_pkg::DP_FETCH_ADDR: opcode <= rd_val[acpu_pkg::DATA_W-1 -: 4];
      acpu_pkg::DP_FETCH_VAL:  opaddr <= rd_val;
      acpu_pkg::DP_EXEC: begin
        unique case (opcode)
          acpu_pkg::OP_HLT: st <= acpu_pkg::ST_HALT;
          acpu_pkg::OP_UNK: st <= acpu_pkg::ST_UNKNOWN;
          acpu_pkg::OP_DIV: begin
            if (rd_val == '0) begin
              st <= acpu_pkg::ST_DIV0;
            end
            div_rem <= '0;
            div_quo <= acc;
            div_dsr <= rd_val;
            div_cnt <= '0;
          end
          default: ;
        endcase
      end
      acpu_pkg::DP_DIV_STEP: begin
        if (!div_trial[acpu_pkg::DATA_W]) begin
          div_rem <= div_trial[acpu_pkg::DATA_W-1:0];
          div_quo <= {div_quo[acpu_pkg::DATA_W-2:0], 1'b1};
        end else begin
          div_rem <= {div_rem[acpu_pkg::DATA_W-2:0], div_quo[acpu_pkg::DATA_W-1]};
          div_quo <= {div_quo[acpu_pkg::DATA_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    sts.halted       = halted;
    sts.opcode       = opcode;
    sts.operand_zero = (rd_val == '0);
    sts.div_last     = (div_cnt == CNT_W'(acpu_pkg::DATA_W - 1));
  end

  // result fields; read data is shown only while the controller strobes it, the others always
  assign read_data       = cmd.result_strobe ? rdata : '0;
  assign pc_now          = pc;
  assign acc_now         = acc;
  assign executed_opcode = opcode;
  assign status          = st;

endmodule

>>> rtl/accumulator_cpu_8bit.sv
// channel   | signals                                        | handshake
// ----------+------------------------------------------------+---------------------------
// request   | kind, address, write_data                      | taken when start & !busy
// result    | read_data, pc_now, acc_now, executed_opcode,   | valid for the one cycle
//           | status                                         | that done is high
//
// write and restart requests, and a step while halted, go from acceptance to done through
// their own state, a read through read and latch states; a step runs fetch opcode, fetch
// operand address, read operand, execute, respond, set by the single memory read port, and
// a divide runs the bit-serial restoring divider between execute and respond.
// busy stays high through the done cycle.
// rst clears pc, accumulator, halt flag and every memory byte (valid bits).
// the receiver cannot stall: the result is shown once and not held.
module accumulator_cpu_8bit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [7:0] address,
  input  logic [7:0] write_data,
  output logic       done,
  output logic [7:0] read_data,
  output logic [7:0] pc_now,
  output logic [7:0] acc_now,
  output logic [3:0] executed_opcode,
  output logic [2:0] status
);

  acpu_pkg::cmd_t cmd;
  acpu_pkg::sts_t sts;

  // sequencing
  acpu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // registers, memory and arithmetic
  acpu_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .address         (address),
    .write_data      (write_data),
    .sts             (sts),
    .read_data       (read_data),
    .pc_now          (pc_now),
    .acc_now         (acc_now),
    .executed_opcode (executed_opcode),
    .status          (status)
  );

  assign done = cmd.result_strobe;

endmodule
